/* design/gte_pkg.sv */
// gte_pkg: shared constants, pipeline timing and the arctangent table for the
// geodetic to ecef conversion unit
// no dependencies
package gte_pkg;

  // number of cordic rotations (range 16 to 48)
  localparam int TRIG_STAGES = 32;

  // fixed-point constants, signed q60 unless noted
  localparam logic signed [63:0] ONE_Q60            = 64'sd1152921504606846976;
  localparam logic signed [63:0] THREE_Q60          = 64'sd3458764513820540928;
  localparam logic signed [63:0] SEMI_MAJOR_MM      = 64'sd6378137000;
  localparam logic signed [63:0] ECC2_Q60           = 64'sd7718094650643698;
  localparam logic signed [63:0] ONE_MINUS_ECC2_Q60 = 64'sd1145203409956203278;
  localparam logic signed [63:0] CORDIC_START_Q60   = 64'sd700114967507363241;
  localparam logic signed [63:0] INT64_MAX          = 64'sh7fffffffffffffff;

  // output clamp bounds, 37-bit signed
  localparam int OUT_W = 37;
  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (OUT_W - 1));

  // rounding shifts of the products
  localparam logic [6:0] SH_Q60  = 7'd60;
  localparam logic [6:0] SH_HALF = 7'd61;
  localparam logic [6:0] SH_N    = 7'd44;
  localparam logic [6:0] SH_OUT  = 7'd76;

  // pipeline timing, cycles after the item is taken
  localparam int MUL_LAT    = 5;
  localparam int COR_LAT    = TRIG_STAGES + 2;
  localparam int L_A        = COR_LAT + MUL_LAT;
  localparam int L_B        = L_A + MUL_LAT;
  localparam int L_D        = L_B + 1;
  localparam int L_Y1       = L_D + 1;
  localparam int NEWTON_LAT = 3 * MUL_LAT + 1;
  localparam int L_Y3       = L_Y1 + 2 * NEWTON_LAT;
  localparam int L_N        = L_Y3 + MUL_LAT;
  localparam int L_S        = L_N + MUL_LAT + 1;
  localparam int L_O        = L_S + MUL_LAT + 1;

  typedef logic signed [63:0] atan_tab_t [TRIG_STAGES];

  // shift-subtract unsigned division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/n) in q60 by the truncated alternating series
  function automatic logic signed [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic signed [63:0] sum;
    logic signed [63:0] term;
    p = udiv64(ONE_Q60, n);
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      if (p != 64'd0) begin
        term = udiv64(p, 64'(2 * k + 1));
        sum = (k % 2 == 1) ? sum - term : sum + term;
        p = udiv64(p, n * n);
      end
    end
    return sum;
  endfunction

  // atan(2^-i) in q60
  function automatic logic signed [63:0] atan_pow2(input int i);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    sum = '0;
    for (int k = 0; k < 31; k++) begin
      if (i * (2 * k + 1) <= 60) begin
        term = udiv64(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
        sum = (k % 2 == 1) ? sum - term : sum + term;
      end
    end
    return sum;
  endfunction

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t tab;
    tab[0] = 64'sd4 * atan_recip(64'd5) - atan_recip(64'd239);
    for (int i = 1; i < TRIG_STAGES; i++) begin
      tab[i] = atan_pow2(i);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();
  localparam logic signed [63:0] PI_Q60      = 64'sd4 * ATAN_TAB[0];
  localparam logic signed [63:0] HALF_PI_Q60 = 64'sd2 * ATAN_TAB[0];

endpackage

/* design/geodetic_to_ecef_unit.sv */
// geodetic_to_ecef_unit: wgs-84 latitude/longitude/height to ecef x, y, z.
// results pass through the cordic chain, the product chain and the newton steps.
// throughput: one item per cycle, busy is always low; results cannot be held off.
// reset: rst_ni (async, low) clears the valid chain only; no result after reset.
// depends on gte_pkg, gte_mul, gte_cordic
module geodetic_to_ecef_unit import gte_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] lat_angle_i,
  input  logic signed [31:0] lon_angle_i,
  input  logic signed [36:0] height_mm_i,
  output logic               done_o,
  output logic signed [36:0] x_mm_o,
  output logic signed [36:0] y_mm_o,
  output logic signed [36:0] z_mm_o
);

  logic signed [63:0] lat_q60, lon_q60;
  logic signed [63:0] clat, slat, clon, slon;
  logic signed [63:0] s2, cc, cs, e2s2;
  logic signed [63:0] d_q, y1_q, y1_sum;
  logic signed [63:0] y_st [3];
  logic signed [63:0] d_dl_q [4*MUL_LAT+2];
  logic signed [63:0] nq, zp;
  logic signed [63:0] nq_dl_q [MUL_LAT];
  logic signed [36:0] h_dl_q [L_N+MUL_LAT];
  logic signed [63:0] hq;
  logic signed [63:0] nhq_q, zq_q;
  logic signed [63:0] cc_dl_q [L_S-L_A];
  logic signed [63:0] cs_dl_q [L_S-L_A];
  logic signed [63:0] slat_dl_q [L_S-COR_LAT];
  logic signed [63:0] xp, yp, zpp;
  logic [L_O-1:0]     vld_q;
  logic               fin_vld;
  logic signed [36:0] x_q, y_q, z_q;

  assign busy = 1'b0;

  // angles to q60
  assign lat_q60 = {{2{lat_angle_i[30]}}, lat_angle_i, 31'd0};
  assign lon_q60 = {lon_angle_i[31], lon_angle_i, 31'd0};

  gte_cordic u_cor_lat (.clk_i(clk_i), .ang_i(lat_q60), .cos_o(clat), .sin_o(slat));
  gte_cordic u_cor_lon (.clk_i(clk_i), .ang_i(lon_q60), .cos_o(clon), .sin_o(slon));

  // sin^2 lat, e2 sin^2 lat and the cos products
  gte_mul u_mul_s2 (.clk_i(clk_i), .a_i(slat), .b_i(slat), .shift_i(SH_Q60), .p_o(s2));
  gte_mul u_mul_cc (.clk_i(clk_i), .a_i(clat), .b_i(clon), .shift_i(SH_Q60), .p_o(cc));
  gte_mul u_mul_cs (.clk_i(clk_i), .a_i(clat), .b_i(slon), .shift_i(SH_Q60), .p_o(cs));
  gte_mul u_mul_e (.clk_i(clk_i), .a_i(ECC2_Q60), .b_i(s2), .shift_i(SH_Q60), .p_o(e2s2));

  // d = 1 - e2 sin^2, first newton step from y = 1 is (3 - d) / 2 rounded
  assign y1_sum = THREE_Q60 - d_q + 64'sd1;
  always_ff @(posedge clk_i) begin
    d_q  <= ONE_Q60 - e2s2;
    y1_q <= y1_sum >>> 1;
  end
  assign y_st[0] = y1_q;

  // d delay line for the later newton steps
  always_ff @(posedge clk_i) begin
    d_dl_q[0] <= d_q;
    for (int j = 1; j < 4 * MUL_LAT + 2; j++) begin
      d_dl_q[j] <= d_dl_q[j-1];
    end
  end

  // remaining newton steps: y = y (3 - d y^2) / 2
  for (genvar k = 0; k < 2; k++) begin : g_newton
    logic signed [63:0] yy, dy2, t_q;
    logic signed [63:0] ydl_q [2*MUL_LAT+1];

    gte_mul u_mul_yy (.clk_i(clk_i), .a_i(y_st[k]), .b_i(y_st[k]), .shift_i(SH_Q60),
                      .p_o(yy));
    gte_mul u_mul_dy (.clk_i(clk_i), .a_i(d_dl_q[MUL_LAT + k * NEWTON_LAT]), .b_i(yy),
                      .shift_i(SH_Q60), .p_o(dy2));

    always_ff @(posedge clk_i) begin
      t_q      <= THREE_Q60 - dy2;
      ydl_q[0] <= y_st[k];
      for (int j = 1; j < 2 * MUL_LAT + 1; j++) begin
        ydl_q[j] <= ydl_q[j-1];
      end
    end

    gte_mul u_mul_y (.clk_i(clk_i), .a_i(ydl_q[2*MUL_LAT]), .b_i(t_q), .shift_i(SH_HALF),
                     .p_o(y_st[k+1]));
  end

  // radius of curvature in q16 mm and its polar form
  gte_mul u_mul_n (.clk_i(clk_i), .a_i(SEMI_MAJOR_MM), .b_i(y_st[2]), .shift_i(SH_N),
                   .p_o(nq));
  gte_mul u_mul_z (.clk_i(clk_i), .a_i(nq), .b_i(ONE_MINUS_ECC2_Q60), .shift_i(SH_Q60),
                   .p_o(zp));

  // delay lines for height, n and the trig terms
  always_ff @(posedge clk_i) begin
    nq_dl_q[0] <= nq;
    for (int j = 1; j < MUL_LAT; j++) begin
      nq_dl_q[j] <= nq_dl_q[j-1];
    end
    h_dl_q[0] <= height_mm_i;
    for (int j = 1; j < L_N + MUL_LAT; j++) begin
      h_dl_q[j] <= h_dl_q[j-1];
    end
    cc_dl_q[0] <= cc;
    cs_dl_q[0] <= cs;
    for (int j = 1; j < L_S - L_A; j++) begin
      cc_dl_q[j] <= cc_dl_q[j-1];
      cs_dl_q[j] <= cs_dl_q[j-1];
    end
    slat_dl_q[0] <= slat;
    for (int j = 1; j < L_S - COR_LAT; j++) begin
      slat_dl_q[j] <= slat_dl_q[j-1];
    end
  end

  // add the height in q16
  assign hq = {{11{h_dl_q[L_N+MUL_LAT-1][36]}}, h_dl_q[L_N+MUL_LAT-1], 16'd0};
  always_ff @(posedge clk_i) begin
    nhq_q <= nq_dl_q[MUL_LAT-1] + hq;
    zq_q  <= zp + hq;
  end

  // final coordinate products
  gte_mul u_mul_x (.clk_i(clk_i), .a_i(nhq_q), .b_i(cc_dl_q[L_S-L_A-1]), .shift_i(SH_OUT),
                   .p_o(xp));
  gte_mul u_mul_yo (.clk_i(clk_i), .a_i(nhq_q), .b_i(cs_dl_q[L_S-L_A-1]), .shift_i(SH_OUT),
                    .p_o(yp));
  gte_mul u_mul_zo (.clk_i(clk_i), .a_i(zq_q), .b_i(slat_dl_q[L_S-COR_LAT-1]),
                    .shift_i(SH_OUT), .p_o(zpp));

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[L_O-2:0], start & ~busy};
    end
  end
  assign fin_vld = vld_q[L_S+MUL_LAT-1];

  // clamp to 37 bits into the output register
  always_ff @(posedge clk_i) begin
    if (fin_vld) begin
      x_q <= (xp > OUT_MAX) ? OUT_MAX[36:0] : (xp < OUT_MIN) ? OUT_MIN[36:0] : xp[36:0];
      y_q <= (yp > OUT_MAX) ? OUT_MAX[36:0] : (yp < OUT_MIN) ? OUT_MIN[36:0] : yp[36:0];
      z_q <= (zpp > OUT_MAX) ? OUT_MAX[36:0] : (zpp < OUT_MIN) ? OUT_MIN[36:0] : zpp[36:0];
    end
  end

  assign done_o = vld_q[L_O-1];
  assign x_mm_o = x_q;
  assign y_mm_o = y_q;
  assign z_mm_o = z_q;

  // d stays positive, which the shortcut first newton step relies on
  a_d_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[L_D-1] |-> !d_q[63]) else $error("d negative");

  // inverse root stays positive through the newton steps
  a_y_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[L_Y3-1] |-> !y_st[2][63]) else $error("inverse root negative");

  // results hold between strobes
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fin_vld |=> ($stable(x_mm_o) && $stable(y_mm_o) && $stable(z_mm_o)))
    else $error("result changed without strobe");

  // strobe follows the final product stage in the next cycle
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld |=> done_o) else $error("strobe lost");

endmodule

/* design/gte_mul.sv */
// gte_mul: pipelined signed 64x64 multiply with round to nearest (ties away
// from zero), right shift and saturation
// depends on gte_pkg
module gte_mul import gte_pkg::*; (
  input  logic               clk_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  input  logic [6:0]         shift_i,
  output logic signed [63:0] p_o
);

  logic [63:0]        ua_q, ub_q;
  logic [3:0]         neg_q;
  logic [63:0]        p00_q, p01_q, p10_q, p11_q;
  logic [127:0]       prod_q;
  logic [127:0]       rnd_q;
  logic [127:0]       half;
  logic [63:0]        mag;
  logic signed [63:0] p_q;

  // magnitudes and result sign
  always_ff @(posedge clk_i) begin
    ua_q     <= a_i[63] ? 64'(-a_i) : 64'(a_i);
    ub_q     <= b_i[63] ? 64'(-b_i) : 64'(b_i);
    neg_q[0] <= a_i[63] ^ b_i[63];
  end

  // 32x32 partial products
  always_ff @(posedge clk_i) begin
    p00_q    <= ua_q[31:0]  * ub_q[31:0];
    p01_q    <= ua_q[31:0]  * ub_q[63:32];
    p10_q    <= ua_q[63:32] * ub_q[31:0];
    p11_q    <= ua_q[63:32] * ub_q[63:32];
    neg_q[1] <= neg_q[0];
  end

  // full product
  always_ff @(posedge clk_i) begin
    prod_q   <= {p11_q, 64'd0} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0}
              + {64'd0, p00_q};
    neg_q[2] <= neg_q[1];
  end

  // round and scale
  assign half = 128'd1 << (shift_i - 7'd1);
  always_ff @(posedge clk_i) begin
    rnd_q    <= (prod_q + half) >> shift_i;
    neg_q[3] <= neg_q[2];
  end

  // saturate and restore sign
  assign mag = (rnd_q > {64'd0, INT64_MAX}) ? INT64_MAX : rnd_q[63:0];
  always_ff @(posedge clk_i) begin
    p_q <= neg_q[3] ? -$signed(mag) : $signed(mag);
  end

  assign p_o = p_q;

endmodule

/* design/gte_cordic.sv */
// gte_cordic: pipelined rotation-mode cordic giving cos and sin in q60,
// with half-turn folding
// depends on gte_pkg
module gte_cordic import gte_pkg::*; (
  input  logic               clk_i,
  input  logic signed [63:0] ang_i,
  output logic signed [63:0] cos_o,
  output logic signed [63:0] sin_o
);

  logic signed [63:0] x_q   [TRIG_STAGES+1];
  logic signed [63:0] y_q   [TRIG_STAGES+1];
  logic signed [63:0] ang_q [TRIG_STAGES+1];
  logic               flip_q[TRIG_STAGES+1];
  logic signed [63:0] cos_q, sin_q;

  // fold angles beyond a quarter turn by pi
  always_ff @(posedge clk_i) begin
    x_q[0] <= CORDIC_START_Q60;
    y_q[0] <= '0;
    if (ang_i > HALF_PI_Q60) begin
      ang_q[0]  <= ang_i - PI_Q60;
      flip_q[0] <= 1'b1;
    end else if (ang_i < -HALF_PI_Q60) begin
      ang_q[0]  <= ang_i + PI_Q60;
      flip_q[0] <= 1'b1;
    end else begin
      ang_q[0]  <= ang_i;
      flip_q[0] <= 1'b0;
    end
  end

  // one rotation per stage
  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
      if (!ang_q[i][63]) begin
        x_q[i+1]   <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1]   <= y_q[i] + (x_q[i] >>> i);
        ang_q[i+1] <= ang_q[i] - ATAN_TAB[i];
      end else begin
        x_q[i+1]   <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1]   <= y_q[i] - (x_q[i] >>> i);
        ang_q[i+1] <= ang_q[i] + ATAN_TAB[i];
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk_i) begin
    cos_q <= flip_q[TRIG_STAGES] ? -x_q[TRIG_STAGES] : x_q[TRIG_STAGES];
    sin_q <= flip_q[TRIG_STAGES] ? -y_q[TRIG_STAGES] : y_q[TRIG_STAGES];
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule
